[hdl/supergrid_taper_stretching_macros.svh]
// Assertion macros shared by the taper block
`ifndef SUPERGRID_TAPER_STRETCHING_MACROS_SVH
`define SUPERGRID_TAPER_STRETCHING_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define STG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define STG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/stg_pkg.sv]
// Package: widths, constants, register indexes and arithmetic helpers for the taper block
`timescale 1ns / 1ps

package stg_pkg;

   localparam int FRAC_BITS  = 16;

   localparam int COORD_W    = 32;
   localparam int EDGE_W     = 35;   // coordinate +/- width, signed, with headroom
   localparam int DIST_W     = 34;
   localparam int INV_W      = 32;
   localparam int WIDTH_W    = 31;
   localparam int PROD_W     = 64;
   localparam int XI_W       = 32;
   localparam int X_W        = 25;   // xi in Q0.24, up to 1.0
   localparam int Q_W        = 38;   // Horner terms, signed Q.24
   localparam int OUT_W      = 17;
   localparam int EPS_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Alignment of the product d*inv (2*FRAC_BITS fraction bits) to Q0.32
   localparam int XI_SHR = (2 * FRAC_BITS >= XI_W) ? 2 * FRAC_BITS - XI_W : 0;
   localparam int XI_SHL = (2 * FRAC_BITS < XI_W) ? XI_W - 2 * FRAC_BITS : 0;

   localparam logic [OUT_W-1:0]   Q16_ONE       = OUT_W'(65536);
   localparam logic [COORD_W-1:0] RIGHT_END_RST = COORD_W'(64'd1 << FRAC_BITS);
   localparam logic [WIDTH_W-1:0] WIDTH_RST     = WIDTH_W'(6554);
   localparam logic [INV_W-1:0]   INV_RST       = INV_W'(655360);
   localparam logic [EPS_W-1:0]   EPS_RST       = EPS_W'(7);

   localparam longint Q24_ONE_L = 64'sd1 <<< 24;
   localparam logic signed [Q_W-1:0] Q24_ONE = Q_W'(Q24_ONE_L);
   localparam logic signed [Q_W-1:0] K462    = Q_W'(462 * Q24_ONE_L);
   localparam logic signed [Q_W-1:0] K1386   = Q_W'(1386 * Q24_ONE_L);
   localparam logic signed [Q_W-1:0] K1980   = Q_W'(1980 * Q24_ONE_L);
   localparam logic signed [Q_W-1:0] K3080   = Q_W'(3080 * Q24_ONE_L);
   localparam logic signed [Q_W-1:0] K3465   = Q_W'(3465 * Q24_ONE_L);
   localparam logic [Q_W-1:0]        K252    = Q_W'(252);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_ENABLE    = 3'd0,
      CSR_RIGHT_ENABLE   = 3'd1,
      CSR_LEFT_START     = 3'd2,
      CSR_RIGHT_END      = 3'd3,
      CSR_TAPER_WIDTH    = 3'd4,
      CSR_INV_TRANSITION = 3'd5,
      CSR_EPS_FLOOR      = 3'd6
   } csr_index_type;

   // Into the polynomial pipeline
   typedef struct packed {
      logic [X_W-1:0] x;
      logic           zero;
      logic           sat;
   } poly_in_type;

   // Out of the polynomial pipeline
   typedef struct packed {
      logic signed [Q_W-1:0] f;
      logic                  zero;
      logic                  sat;
   } poly_out_type;

   // a * x, magnitude rounded half up, sign restored
   function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                  input logic [X_W-1:0] x);
      logic [Q_W-1:0]     m;
      logic [Q_W+X_W-1:0] p;
      logic [Q_W-1:0]     r;
      m = a[Q_W-1] ? $unsigned(-a) : $unsigned(a);
      p = (Q_W+X_W)'(m) * (Q_W+X_W)'(x) + (Q_W+X_W)'(24'h800000);
      r = Q_W'(p >> 24);
      return a[Q_W-1] ? $signed(-r) : $signed(r);
   endfunction

   // Unsigned Q0.24 product, rounded half up
   function automatic logic [X_W-1:0] rmul(input logic [X_W-1:0] a, input logic [X_W-1:0] b);
      logic [2*X_W-1:0] p;
      p = (2*X_W)'(a) * (2*X_W)'(b) + (2*X_W)'(24'h800000);
      return X_W'(p >> 24);
   endfunction

endpackage

[hdl/stg_if.sv]
// Channel interfaces: coordinate requests, results and register writes
`timescale 1ns / 1ps

interface stg_req_if;
   import stg_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coord;
   modport source (output valid, output coord, input ready);
   modport sink   (input valid, input coord, output ready);
endinterface

interface stg_rsp_if;
   import stg_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] damping;
   logic [OUT_W-1:0] stretch;
   modport source (output valid, output damping, output stretch, input ready);
   modport sink   (input valid, input damping, input stretch, output ready);
endinterface

interface stg_csr_if;
   import stg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/stg_poly.sv]
// Six-stage pipeline for the degree-11 smoothstep polynomial (Horner plus xi^6)
`timescale 1ns / 1ps

module stg_poly (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  stg_pkg::poly_in_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stg_pkg::poly_out_type out_data
);
   import stg_pkg::*;

   localparam int NS = 6;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] en;
   logic [NS-1:0] zero_ff;
   logic [NS-1:0] zero_in;
   logic [NS-1:0] sat_ff;
   logic [NS-1:0] sat_in;

   // Horner terms, one per stage
   logic signed [Q_W-1:0] q1_ff, q2_ff, q3_ff, q4_ff, q5_ff, f_ff;
   logic signed [Q_W-1:0] q1_in, q2_in, q3_in, q4_in, q5_in, f_in;
   // x carried alongside, powers of x
   logic [X_W-1:0] xa_ff, xb_ff, xc_ff, xd_ff;
   logic [X_W-1:0] x2_ff, x3_ff, x6c_ff, x6d_ff, x6e_ff;
   logic [X_W-1:0] x2_in, x3_in, x6_in;

   // A stage moves when it is empty or the one after it moves
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in  = {vld_ff[NS-2:0], in_valid};
   assign zero_in = {zero_ff[NS-2:0], in_data.zero};
   assign sat_in  = {sat_ff[NS-2:0], in_data.sat};

   assign q1_in = K1386 - $signed(Q_W'(in_data.x) * K252);
   assign x2_in = rmul(in_data.x, in_data.x);
   assign q2_in = mulq(q1_ff, xa_ff) - K3080;
   assign x3_in = rmul(x2_ff, xa_ff);
   assign q3_in = mulq(q2_ff, xb_ff) + K3465;
   assign x6_in = rmul(x3_ff, x3_ff);
   assign q4_in = mulq(q3_ff, xc_ff) - K1980;
   assign q5_in = mulq(q4_ff, xd_ff) + K462;
   assign f_in  = mulq(q5_ff, x6e_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            zero_ff[k] <= zero_in[k];
            sat_ff[k]  <= sat_in[k];
         end
      end
      if (en[0]) begin
         q1_ff <= q1_in;
         x2_ff <= x2_in;
         xa_ff <= in_data.x;
      end
      if (en[1]) begin
         q2_ff <= q2_in;
         x3_ff <= x3_in;
         xb_ff <= xa_ff;
      end
      if (en[2]) begin
         q3_ff  <= q3_in;
         x6c_ff <= x6_in;
         xc_ff  <= xb_ff;
      end
      if (en[3]) begin
         q4_ff  <= q4_in;
         x6d_ff <= x6c_ff;
         xd_ff  <= xc_ff;
      end
      if (en[4]) begin
         q5_ff  <= q5_in;
         x6e_ff <= x6d_ff;
      end
      if (en[5]) begin
         f_ff <= f_in;
      end
   end

   assign in_ready      = en[0];
   assign out_valid     = vld_ff[NS-1];
   assign out_data.f    = f_ff;
   assign out_data.zero = zero_ff[NS-1];
   assign out_data.sat  = sat_ff[NS-1];

endmodule

[hdl/supergrid_taper_stretching.sv]
// Top level: absorbing-layer taper, damping coefficient and stretching factor per coordinate
//
//   channel   dir   payload                       transfer when
//   req_ch    in    coord (s32, Q16.16)           valid && ready
//   rsp_ch    out   damping, stretch (u17, Q1.16) valid && ready
//   csr_ch    in    index (3b), data (32b)        valid && ready (ready tied high)
//
// One coordinate per cycle; eleven register stages from request transfer to result valid:
// edge compare, d*inv multiply, xi align, six multiply stages of the polynomial, clamp, stretch.
// Each stage holds its own valid bit and moves when empty or when the next stage moves,
// so bubbles are squeezed out and a stalled result does not block intake until the pipe fills.
// Reset (synchronous) empties the pipe and loads the register defaults.
`timescale 1ns / 1ps
`include "supergrid_taper_stretching_macros.svh"

module supergrid_taper_stretching (
   input  logic       clock,
   input  logic       reset,
   stg_req_if.sink    req_ch,
   stg_rsp_if.source  rsp_ch,
   stg_csr_if.sink    csr_ch
);
   import stg_pkg::*;

   // ---------------- configuration registers ----------------
   logic                      left_en_ff;
   logic                      right_en_ff;
   logic [COORD_W-1:0]        left_start_ff;
   logic [COORD_W-1:0]        right_end_ff;
   logic [WIDTH_W-1:0]        width_ff;
   logic [INV_W-1:0]          inv_ff;
   logic [EPS_W-1:0]          eps_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_en_ff    <= 1'b0;
         right_en_ff   <= 1'b0;
         left_start_ff <= '0;
         right_end_ff  <= RIGHT_END_RST;
         width_ff      <= WIDTH_RST;
         inv_ff        <= INV_RST;
         eps_ff        <= EPS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_LEFT_ENABLE:    left_en_ff    <= csr_ch.data[0];
            CSR_RIGHT_ENABLE:   right_en_ff   <= csr_ch.data[0];
            CSR_LEFT_START:     left_start_ff <= csr_ch.data;
            CSR_RIGHT_END:      right_end_ff  <= csr_ch.data;
            CSR_TAPER_WIDTH:    width_ff      <= csr_ch.data[WIDTH_W-1:0];
            CSR_INV_TRANSITION: inv_ff        <= csr_ch.data;
            CSR_EPS_FLOOR:      eps_ff        <= csr_ch.data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- front: distance, product, xi ----------------
   logic [2:0] fvld_ff;
   logic [2:0] fen;
   logic       poly_in_ready;

   logic signed [EDGE_W-1:0] x_s, width_s, ledge, redge, dl, dr;
   logic                     left_hit, right_hit;
   logic [DIST_W-1:0]        d_in, d_ff;
   logic                     hit_in, s1_hit_ff, s2_hit_ff;
   logic [PROD_W-1:0]        prod_in, prod_ff;
   logic                     sat1_in, sat1_ff;
   logic [XI_W-1:0]          xi;
   logic                     sat_in, zero_in;
   logic [X_W-1:0]           x_in;
   poly_in_type              s3_ff;

   always_comb begin
      fen[2] = !fvld_ff[2] || poly_in_ready;
      fen[1] = !fvld_ff[1] || fen[2];
      fen[0] = !fvld_ff[0] || fen[1];
   end
   assign req_ch.ready = fen[0];

   assign x_s     = EDGE_W'(req_ch.coord);
   assign width_s = $signed(EDGE_W'(width_ff));
   assign ledge   = EDGE_W'($signed(left_start_ff)) + width_s;
   assign redge   = EDGE_W'($signed(right_end_ff)) - width_s;
   assign dl      = ledge - x_s;
   assign dr      = x_s - redge;

   // Left taper has priority when both ranges match
   assign left_hit  = left_en_ff && !dl[EDGE_W-1] && (dl != '0);
   assign right_hit = right_en_ff && !dr[EDGE_W-1] && (dr != '0);
   assign hit_in    = left_hit || right_hit;

   always_comb begin
      priority if (left_hit) begin
         d_in = dl[DIST_W-1:0];
      end else if (right_hit) begin
         d_in = dr[DIST_W-1:0];
      end else begin
         d_in = '0;
      end
   end

   // d at or above 2^32 saturates unless the reciprocal is zero
   assign prod_in = PROD_W'(d_ff[31:0]) * PROD_W'(inv_ff);
   assign sat1_in = (d_ff[DIST_W-1:32] != '0) && (inv_ff != '0);

   assign sat_in  = sat1_ff || ((prod_ff >> (2 * FRAC_BITS)) != '0);
   assign xi      = XI_W'((prod_ff >> XI_SHR) << XI_SHL);
   assign zero_in = !s2_hit_ff || (!sat_in && (xi == '0));
   assign x_in    = X_W'(((XI_W + 1)'(xi) + (XI_W + 1)'(128)) >> 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= '0;
      end else begin
         if (fen[0]) fvld_ff[0] <= req_ch.valid;
         if (fen[1]) fvld_ff[1] <= fvld_ff[0];
         if (fen[2]) fvld_ff[2] <= fvld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (fen[0]) begin
         d_ff      <= d_in;
         s1_hit_ff <= hit_in;
      end
      if (fen[1]) begin
         prod_ff   <= prod_in;
         sat1_ff   <= sat1_in;
         s2_hit_ff <= s1_hit_ff;
      end
      if (fen[2]) begin
         s3_ff.x    <= x_in;
         s3_ff.zero <= zero_in;
         s3_ff.sat  <= sat_in;
      end
   end

   // ---------------- polynomial ----------------
   logic         poly_out_valid;
   logic         poly_out_ready;
   poly_out_type poly_out;

   stg_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fvld_ff[2]),
      .in_ready  (poly_in_ready),
      .in_data   (s3_ff),
      .out_valid (poly_out_valid),
      .out_ready (poly_out_ready),
      .out_data  (poly_out)
   );

   // ---------------- back: clamp, round, stretch ----------------
   logic                   bvld_ff;
   logic                   rsp_vld_ff;
   logic                   ben;
   logic                   oen;
   logic [X_W-1:0]         fc;
   logic [OUT_W-1:0]       fr;
   logic [OUT_W-1:0]       damp_in, damp_ff;
   logic [OUT_W-1:0]       rsp_damp_ff, rsp_stretch_ff;
   logic [EPS_W-1:0]       eps_c;
   logic [OUT_W-1:0]       one_minus_eps;
   logic [2*OUT_W-1:0]     drop_prod;
   logic [OUT_W-1:0]       drop;
   logic [OUT_W-1:0]       stretch_in;

   assign oen            = !rsp_vld_ff || rsp_ch.ready;
   assign ben            = !bvld_ff || oen;
   assign poly_out_ready = ben;

   always_comb begin
      priority if (poly_out.f[Q_W-1]) begin
         fc = '0;
      end else if (poly_out.f > Q24_ONE) begin
         fc = X_W'(Q24_ONE);
      end else begin
         fc = poly_out.f[X_W-1:0];
      end
   end
   assign fr = OUT_W'(((X_W + 1)'(fc) + (X_W + 1)'(128)) >> 8);

   always_comb begin
      priority if (poly_out.zero) begin
         damp_in = '0;
      end else if (poly_out.sat) begin
         damp_in = Q16_ONE;
      end else if (fr > Q16_ONE) begin
         damp_in = Q16_ONE;
      end else begin
         damp_in = fr;
      end
   end

   assign eps_c         = (eps_ff > Q16_ONE) ? Q16_ONE : eps_ff;
   assign one_minus_eps = Q16_ONE - eps_c;
   assign drop_prod     = (2*OUT_W)'(one_minus_eps) * (2*OUT_W)'(damp_ff)
                        + (2*OUT_W)'(32768);
   assign drop          = OUT_W'(drop_prod >> 16);
   assign stretch_in    = Q16_ONE - drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (ben) bvld_ff    <= poly_out_valid;
         if (oen) rsp_vld_ff <= bvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         damp_ff <= damp_in;
      end
      if (oen) begin
         rsp_damp_ff    <= damp_ff;
         rsp_stretch_ff <= stretch_in;
      end
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.damping = rsp_damp_ff;
   assign rsp_ch.stretch = rsp_stretch_ff;

   // ---------------- checks ----------------
   `STG_ASSERT_NEXT(a_intake_lands, req_ch.valid && req_ch.ready, fvld_ff[0], "intake lost")
   `STG_ASSERT_SAME(a_sat_not_zero, fvld_ff[2] && s3_ff.sat, !s3_ff.zero, "sat and zero")
   `STG_ASSERT_SAME(a_unit_str, rsp_vld_ff && rsp_damp_ff == '0, rsp_stretch_ff == Q16_ONE, "str")
   `STG_ASSERT_SAME(a_out_range, rsp_vld_ff, rsp_damp_ff <= Q16_ONE && rsp_stretch_ff <= Q16_ONE, "big")

endmodule

[dv/supergrid_taper_stretching_test.sv]
// Testbench for the absorbing-layer taper: damping and stretch per coordinate, checked in order
`timescale 1ns / 1ps

module supergrid_taper_stretching_test;
   import stg_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1130;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;   // unmapped index, writes are dropped
   localparam longint ONE24 = 64'sd1 <<< 24;
   localparam longint unsigned HALF24 = 64'd1 << 23;

   typedef struct packed {
      logic [OUT_W-1:0] damping;
      logic [OUT_W-1:0] stretch;
   } taper_result_type;

   typedef struct packed {
      logic                      left_en;
      logic                      right_en;
      logic signed [COORD_W-1:0] left_start;
      logic signed [COORD_W-1:0] right_end;
      logic [WIDTH_W-1:0]        width;
      logic [INV_W-1:0]          inv;
      logic [EPS_W-1:0]          eps;
   } taper_setting_type;

   typedef enum bit {ROW_WRITE, ROW_COORD} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           value;
      bit                    known;
      logic [OUT_W-1:0]      damping;
      logic [OUT_W-1:0]      stretch;
   } plan_row_type;

   logic clock;
   logic reset;

   stg_req_if req_ch();
   stg_rsp_if rsp_ch();
   stg_csr_if csr_ch();

   supergrid_taper_stretching uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   taper_setting_type taper_regs;
   taper_result_type  taper_due_q[$];
   plan_row_type      directed_plan[$];
   int unsigned       sender_idle_pct;
   int unsigned       receiver_idle_pct;
   int unsigned       fail_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("supergrid_taper_stretching test failed");
      $finish;
   end

   // a * x with x in Q0.24; magnitude rounded half up, sign put back
   function automatic longint round_mul_q24(longint a, longint unsigned x);
      longint unsigned mag;
      longint unsigned p;
      mag = (a < 0) ? -a : a;
      p = (mag * x + HALF24) >> 24;
      return (a < 0) ? -longint'(p) : longint'(p);
   endfunction

   // d * inv aligned to Q0.32, pinned at 1.0
   function automatic logic [XI_W:0] xi_from_distance(logic [DIST_W-1:0] d,
                                                      logic [INV_W-1:0] inv);
      logic [65:0] prod;
      prod = {32'b0, d} * {34'b0, inv};
      if (prod >= (66'd1 << (2 * FRAC_BITS)))
         return 33'h1_0000_0000;
      return 33'((prod >> XI_SHR) << XI_SHL);
   endfunction

   // Degree-11 smoothstep, Horner in signed Q.24, result in Q1.16
   function automatic logic [OUT_W-1:0] c5_smoothstep(logic [XI_W:0] xi);
      longint unsigned x, x2, x3, x6;
      longint          q, f;
      if (xi == 0)
         return '0;
      if (xi[XI_W])
         return Q16_ONE;
      x = ({31'b0, xi} + 64'd128) >> 8;
      q = -252 * ONE24;
      q = round_mul_q24(q, x) + 1386 * ONE24;
      q = round_mul_q24(q, x) - 3080 * ONE24;
      q = round_mul_q24(q, x) + 3465 * ONE24;
      q = round_mul_q24(q, x) - 1980 * ONE24;
      q = round_mul_q24(q, x) + 462 * ONE24;
      x2 = (x * x + HALF24) >> 24;
      x3 = (x2 * x + HALF24) >> 24;
      x6 = (x3 * x3 + HALF24) >> 24;
      f = round_mul_q24(q, x6);
      if (f < 0)
         f = 0;
      if (f > ONE24)
         f = ONE24;
      f = (f + 128) >> 8;
      return (f > 65536) ? Q16_ONE : OUT_W'(f);
   endfunction

   function automatic taper_result_type taper_of_coord(logic signed [COORD_W-1:0] coord);
      taper_result_type res;
      longint           xc, ledge, redge;
      longint unsigned  dmp, e, drop;
      xc = longint'(coord);
      ledge = longint'(taper_regs.left_start) + longint'(taper_regs.width);
      redge = longint'(taper_regs.right_end) - longint'(taper_regs.width);
      res.damping = '0;
      // left side takes priority when both layers claim the point
      if (taper_regs.left_en && xc < ledge)
         res.damping = c5_smoothstep(xi_from_distance(34'(ledge - xc), taper_regs.inv));
      else if (taper_regs.right_en && xc > redge)
         res.damping = c5_smoothstep(xi_from_distance(34'(xc - redge), taper_regs.inv));
      e = (taper_regs.eps > Q16_ONE) ? 64'd65536 : 64'(taper_regs.eps);
      dmp = 64'(res.damping);
      drop = ((64'd65536 - e) * dmp + 64'd32768) >> 16;
      res.stretch = OUT_W'(64'd65536 - drop);
      return res;
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      return '{ROW_WRITE, idx, v, 1'b0, '0, '0};
   endfunction

   function automatic plan_row_type pred_row(logic [31:0] c);
      return '{ROW_COORD, '0, c, 1'b0, '0, '0};
   endfunction

   function automatic plan_row_type known_row(logic [31:0] c, logic [OUT_W-1:0] d,
                                              logic [OUT_W-1:0] s);
      return '{ROW_COORD, '0, c, 1'b1, d, s};
   endfunction

   // Leaves valid high so back-to-back writes need no second assignment in a step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_LEFT_ENABLE:    taper_regs.left_en    = data[0];
         CSR_RIGHT_ENABLE:   taper_regs.right_en   = data[0];
         CSR_LEFT_START:     taper_regs.left_start = data;
         CSR_RIGHT_END:      taper_regs.right_end  = data;
         CSR_TAPER_WIDTH:    taper_regs.width      = data[WIDTH_W-1:0];
         CSR_INV_TRANSITION: taper_regs.inv        = data;
         CSR_EPS_FLOOR:      taper_regs.eps        = data[EPS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_coord(input logic [31:0] c, input bit known,
                             input taper_result_type typed);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.coord <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      taper_due_q.push_back(known ? typed : taper_of_coord(c));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (taper_due_q.size() != 0) @(posedge clock);
   endtask

   initial begin : result_side
      taper_result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (taper_due_q.size() == 0) begin
               $error("result transfer with nothing expected: damping %0d stretch %0d",
                      rsp_ch.damping, rsp_ch.stretch);
               fail_count++;
            end else begin
               want = taper_due_q.pop_front();
               if (rsp_ch.damping !== want.damping) begin
                  $error("damping: expected %0d, got %0d", want.damping, rsp_ch.damping);
                  fail_count++;
               end
               if (rsp_ch.stretch !== want.stretch) begin
                  $error("stretch: expected %0d, got %0d", want.stretch, rsp_ch.stretch);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   initial begin : stimulus
      plan_row_type       row;
      bit                 in_writes;
      bit                 le, re;
      int unsigned        sent, n, trans;
      longint             lstart, rend, ledge, redge, off;
      logic [WIDTH_W-1:0] w;
      logic [INV_W-1:0]   inv;
      logic [EPS_W-1:0]   eps;
      logic [31:0]        c;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.coord <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data  <= '0;
      taper_regs = '{1'b0, 1'b0, '0, RIGHT_END_RST, WIDTH_RST, INV_RST, EPS_RST};
      sender_idle_pct   = 24;
      receiver_idle_pct = 52;

      // both layers off after reset
      directed_plan.push_back(known_row(32'h0000_0000, 17'd0, 17'd65536));
      directed_plan.push_back(known_row(32'h7FFF_FFFF, 17'd0, 17'd65536));
      directed_plan.push_back(known_row(32'h8000_0000, 17'd0, 17'd65536));
      // left layer with default geometry: deep inside saturates, stretch falls to eps
      directed_plan.push_back(reg_row(CSR_LEFT_ENABLE, 32'd1));
      directed_plan.push_back(known_row(32'h8000_0000, 17'd65536, 17'd7));
      directed_plan.push_back(known_row(32'd6554, 17'd0, 17'd65536));
      directed_plan.push_back(pred_row(32'd6553));
      directed_plan.push_back(pred_row(32'd3277));
      directed_plan.push_back(known_row(32'd0, 17'd65536, 17'd7));
      // overlapping layers: left must win
      directed_plan.push_back(reg_row(CSR_RIGHT_ENABLE, 32'd1));
      directed_plan.push_back(reg_row(CSR_RIGHT_END, 32'd0));
      directed_plan.push_back(pred_row(32'd3277));
      directed_plan.push_back(known_row(32'h7FFF_FFFF, 17'd65536, 17'd7));
      // zero reciprocal gives no damping
      directed_plan.push_back(reg_row(CSR_INV_TRANSITION, 32'd0));
      directed_plan.push_back(known_row(32'd3277, 17'd0, 17'd65536));
      // largest reciprocal: xi just under one rounds up to one
      directed_plan.push_back(reg_row(CSR_INV_TRANSITION, 32'hFFFF_FFFF));
      directed_plan.push_back(pred_row(32'd6553));
      // eps beyond one is pinned at one
      directed_plan.push_back(reg_row(CSR_EPS_FLOOR, 32'h0001_FFFF));
      directed_plan.push_back(known_row(32'h8000_0000, 17'd65536, 17'd65536));
      directed_plan.push_back(reg_row(CSR_EPS_FLOOR, 32'd0));
      directed_plan.push_back(known_row(32'h8000_0000, 17'd65536, 17'd0));
      directed_plan.push_back(reg_row(CSR_EPS_FLOOR, 32'h0001_0000));
      directed_plan.push_back(known_row(32'd5000, 17'd65536, 17'd65536));
      // widest geometry, distances past 32 bits
      directed_plan.push_back(reg_row(CSR_LEFT_START, 32'h7FFF_FFFF));
      directed_plan.push_back(reg_row(CSR_TAPER_WIDTH, 32'h7FFF_FFFF));
      directed_plan.push_back(reg_row(CSR_INV_TRANSITION, 32'd1));
      directed_plan.push_back(known_row(32'h8000_0000, 17'd65536, 17'd65536));
      directed_plan.push_back(pred_row(32'h7FFF_FFFF));
      directed_plan.push_back(reg_row(CSR_NO_REG, 32'd0));
      directed_plan.push_back(reg_row(CSR_LEFT_ENABLE, 32'd0));
      directed_plan.push_back(reg_row(CSR_RIGHT_END, 32'h8000_0000));
      directed_plan.push_back(pred_row(32'h8000_0000));
      directed_plan.push_back(known_row(32'h7FFF_FFFF, 17'd65536, 17'd65536));
      // zero width, right edge at the top of the range
      directed_plan.push_back(reg_row(CSR_TAPER_WIDTH, 32'd0));
      directed_plan.push_back(reg_row(CSR_RIGHT_END, 32'h7FFF_FFFF));
      directed_plan.push_back(known_row(32'h7FFF_FFFF, 17'd0, 17'd65536));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      in_writes = 1'b0;
      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_WRITE) begin
            if (!in_writes)
               wait_idle();
            in_writes = 1'b1;
            write_reg(row.index, row.value);
         end else begin
            if (in_writes)
               csr_ch.valid <= 1'b0;
            in_writes = 1'b0;
            send_coord(row.value, row.known, '{row.damping, row.stretch});
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (sent >= RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 52;
            receiver_idle_pct = 24;
         end else begin
            sender_idle_pct   = 24;
            receiver_idle_pct = 52;
         end
         wait_idle();

         le = 1'($urandom_range(0, 1));
         re = 1'($urandom_range(0, 1));
         if (!le && !re && $urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 1))
               le = 1'b1;
            else
               re = 1'b1;
         end
         if ($urandom_range(0, 9) == 0)
            lstart = longint'($signed($urandom));
         else
            lstart = longint'($urandom_range(0, 1 << 21)) - longint'(1 << 20);
         if ($urandom_range(0, 9) == 0)
            rend = longint'($signed($urandom));
         else
            rend = lstart + longint'($urandom_range(0, 1 << 21));
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = WIDTH_W'($urandom);
            default: w = WIDTH_W'($urandom_range(0, 1 << 18));
         endcase
         trans = $urandom_range(2, 1 << 18);
         case ($urandom_range(0, 19))
            0:       inv = '0;
            1:       inv = 32'd1;
            2:       inv = '1;
            3, 4:    inv = $urandom;
            default: inv = INV_W'((64'd1 << 32) / trans);
         endcase
         case ($urandom_range(0, 19))
            0, 1:    eps = '0;
            2, 3:    eps = 17'd65536;
            4:       eps = EPS_W'($urandom_range(65537, 131071));
            default: eps = EPS_W'($urandom_range(0, 65536));
         endcase

         write_reg(CSR_LEFT_ENABLE, {31'b0, le});
         write_reg(CSR_RIGHT_ENABLE, {31'b0, re});
         write_reg(CSR_LEFT_START, 32'(lstart));
         write_reg(CSR_RIGHT_END, 32'(rend));
         write_reg(CSR_TAPER_WIDTH, {1'b0, w});
         write_reg(CSR_INV_TRANSITION, inv);
         write_reg(CSR_EPS_FLOOR, {15'b0, eps});
         if ($urandom_range(0, 4) == 0)
            write_reg(CSR_NO_REG, $urandom);
         csr_ch.valid <= 1'b0;

         ledge = longint'(taper_regs.left_start) + longint'(taper_regs.width);
         redge = longint'(taper_regs.right_end) - longint'(taper_regs.width);
         n = $urandom_range(8, 48);
         if (n > RANDOM_ITEMS - sent)
            n = RANDOM_ITEMS - sent;
         repeat (n) begin
            // aim mostly across the transition band, a little past either side
            off = longint'($urandom_range(0, trans + trans / 4)) - longint'(trans / 8);
            case ($urandom_range(0, 9))
               0, 1:       c = $urandom;
               2, 3, 4, 5: c = 32'(ledge - off);
               default:    c = 32'(redge + off);
            endcase
            send_coord(c, 1'b0, '0);
         end
         sent += n;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("supergrid_taper_stretching test passed");
      else
         $display("supergrid_taper_stretching test failed");
      $finish;
   end

endmodule
